>>> hw/rtl/largest_prime_in_stream_defines.svh
// Assertion macros shared by the largest_prime_in_stream RTL files.
// No dependencies; included by bare file name where assertions are written.
`ifndef LARGEST_PRIME_IN_STREAM_DEFINES_SVH
`define LARGEST_PRIME_IN_STREAM_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/lpis_pkg.sv
// Package for largest_prime_in_stream: widths, constants and control structs.
// Used by the interfaces, the remainder unit and the top level.
package lpis_pkg;

    localparam int VALUE_W = 32;           // input value width, signed
    localparam int MAG_W   = VALUE_W - 1;  // magnitude of a non-negative value
    localparam int DIV_W   = 16;           // trial divisor, covers sqrt(2^31)
    localparam int DSQ_W   = 2 * DIV_W;    // divisor squared
    localparam int REM_W   = DIV_W;        // remainder is always below the divisor
    localparam int CNT_W   = $clog2(MAG_W);

    localparam logic [MAG_W-1:0] SMALLEST_PRIME = MAG_W'(2);
    localparam logic [DIV_W-1:0] FIRST_DIV      = DIV_W'(3);
    localparam logic [DSQ_W-1:0] FIRST_DSQ      = DSQ_W'(9);
    localparam logic [DIV_W-1:0] DIV_STEP       = DIV_W'(2);
    localparam logic [DSQ_W-1:0] DSQ_STEP_CONST = DSQ_W'(4);

    typedef struct packed {
        logic start;
    } t_rem_ctrl;

    typedef struct packed {
        logic done;
        logic zero;
    } t_rem_status;

endpackage

>>> hw/rtl/lpis_if.sv
// Channel interfaces for largest_prime_in_stream: input items and results.
// Depends on lpis_pkg for the field widths.
interface lpis_in_if;
    logic                          valid;
    logic                          ready;
    logic signed [lpis_pkg::VALUE_W-1:0] value;
    logic                          last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface lpis_out_if;
    logic                        valid;
    logic                        ready;
    logic [lpis_pkg::MAG_W-1:0]  largest_prime;

    modport source (output valid, output largest_prime, input ready);
    modport sink   (input valid, input largest_prime, output ready);
endinterface

>>> hw/rtl/lpis_rem.sv
// Bit-serial remainder unit: dividend mod divisor, one restoring step per cycle.
// Depends on lpis_pkg for widths and the control and status structs.
module lpis_rem (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lpis_pkg::t_rem_ctrl         i_ctrl,
    input  logic [lpis_pkg::MAG_W-1:0]  i_dividend,
    input  logic [lpis_pkg::DIV_W-1:0]  i_divisor,
    output lpis_pkg::t_rem_status       o_status
);

    logic                        r_busy, n_busy;
    logic                        r_done, n_done;
    logic [lpis_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [lpis_pkg::MAG_W-1:0]  r_dvd, n_dvd;
    logic [lpis_pkg::DIV_W-1:0]  r_dsr, n_dsr;
    logic [lpis_pkg::REM_W-1:0]  r_rem, n_rem;
    logic [lpis_pkg::REM_W:0]    w_trial;
    logic [lpis_pkg::REM_W:0]    w_diff;

    // Bring down the next dividend bit and subtract the divisor when it fits.
    assign w_trial = {r_rem, r_dvd[lpis_pkg::MAG_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_rem  = r_rem;
        if (i_ctrl.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, r_dsr}) begin
                n_rem = w_diff[lpis_pkg::REM_W-1:0];
            end else begin
                n_rem = w_trial[lpis_pkg::REM_W-1:0];
            end
            n_dvd = {r_dvd[lpis_pkg::MAG_W-2:0], 1'b0};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == lpis_pkg::CNT_W'(lpis_pkg::MAG_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
        r_rem <= n_rem;
    end

    assign o_status.done = r_done;
    assign o_status.zero = (r_rem == '0);

endmodule

>>> hw/rtl/largest_prime_in_stream.sv
// Top level of largest_prime_in_stream: sequencer, running maximum, result register.
// Depends on lpis_pkg, lpis_if.sv, lpis_rem and largest_prime_in_stream_defines.svh.
//
// Usage: signed 32-bit values arrive one transfer at a time on i_in, with
// last_item set on the final value of a data set. Each value is tested for
// primality by trial division with odd divisors 3, 5, 7, ... while d*d <= value.
// After the transfer flagged last, one result transfer on o_out carries the
// largest prime of the set, or 0 when the set held none, and the running
// maximum is cleared for the next set.
// Processing: one value is processed at a time and i_in.ready is low
// while it is. Negative values, 0, 1, 2 and even values need no trial. Odd values
// take a bound check per divisor tried and a pass of the bit-serial remainder
// unit, which makes one restoring step per cycle over the 31 magnitude bits.
// A prime near 2^31 tries about 23,170 divisors.
// Reset (synchronous, active low) clears the sequencer, the running maximum and
// the output valid flag.
// Stalls: the result sits in an output register, so a new value is taken while
// a result waits. Only the next last-flagged value waits, in its final cycle,
// until the pending result has been transferred.
`include "largest_prime_in_stream_defines.svh"

module largest_prime_in_stream (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lpis_in_if.sink     i_in,
    lpis_out_if.source  o_out
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CHECK  = 2'd1;
    localparam logic [1:0] ST_DIV    = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [lpis_pkg::MAG_W-1:0]  r_v, n_v;
    logic                        r_last, n_last;
    logic                        r_prime, n_prime;
    logic [lpis_pkg::DIV_W-1:0]  r_div, n_div;
    logic [lpis_pkg::DSQ_W-1:0]  r_dsq, n_dsq;
    logic [lpis_pkg::MAG_W-1:0]  r_best, n_best;
    logic                        r_out_valid, n_out_valid;
    logic [lpis_pkg::MAG_W-1:0]  r_out_data, n_out_data;

    lpis_pkg::t_rem_ctrl   s_rem_ctrl;
    lpis_pkg::t_rem_status s_rem_status;

    logic                        w_accept;
    logic                        w_emit;
    logic [lpis_pkg::MAG_W-1:0]  w_cand;
    logic [lpis_pkg::MAG_W-1:0]  w_in_mag;

    // The shared remainder unit computes value mod divisor for each trial.
    lpis_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (s_rem_ctrl),
        .i_dividend (r_v),
        .i_divisor  (r_div),
        .o_status   (s_rem_status)
    );

    assign i_in.ready = (r_state == ST_IDLE);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_in_mag   = i_in.value[lpis_pkg::MAG_W-1:0];

    // The new maximum, should the value just tested be a prime above it.
    assign w_cand = (r_prime && (r_v > r_best)) ? r_v : r_best;

    // A last-flagged value may finish only once the output register is free.
    assign w_emit = (r_state == ST_FINISH) && r_last && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state          = r_state;
        n_v              = r_v;
        n_last           = r_last;
        n_prime          = r_prime;
        n_div            = r_div;
        n_dsq            = r_dsq;
        n_best           = r_best;
        n_out_data       = r_out_data;
        n_out_valid      = r_out_valid && !o_out.ready;
        s_rem_ctrl.start = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_v     = w_in_mag;
                    n_last  = i_in.last_item;
                    n_div   = lpis_pkg::FIRST_DIV;
                    n_dsq   = lpis_pkg::FIRST_DSQ;
                    n_state = ST_FINISH;
                    // Negative values, 0 and 1 are not prime; 2 is the one even prime.
                    if (i_in.value[lpis_pkg::VALUE_W-1]
                            || (w_in_mag < lpis_pkg::SMALLEST_PRIME)) begin
                        n_prime = 1'b0;
                    end else if (w_in_mag == lpis_pkg::SMALLEST_PRIME) begin
                        n_prime = 1'b1;
                    end else if (!w_in_mag[0]) begin
                        n_prime = 1'b0;
                    end else begin
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                // Once the divisor squared passes the value, no factor is left to find.
                if (r_dsq > {1'b0, r_v}) begin
                    n_prime = 1'b1;
                    n_state = ST_FINISH;
                end else begin
                    s_rem_ctrl.start = 1'b1;
                    n_state          = ST_DIV;
                end
            end
            ST_DIV: begin
                if (s_rem_status.done) begin
                    if (s_rem_status.zero) begin
                        n_prime = 1'b0;
                        n_state = ST_FINISH;
                    end else begin
                        // (d + 2)^2 = d^2 + 4d + 4
                        n_div   = r_div + lpis_pkg::DIV_STEP;
                        n_dsq   = r_dsq
                                  + {{(lpis_pkg::DSQ_W - lpis_pkg::DIV_W - 2){1'b0}},
                                     r_div, 2'b00}
                                  + lpis_pkg::DSQ_STEP_CONST;
                        n_state = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                if (!r_last) begin
                    n_best  = w_cand;
                    n_state = ST_IDLE;
                end else if (w_emit) begin
                    n_out_data  = w_cand;
                    n_out_valid = 1'b1;
                    n_best      = '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_best      <= n_best;
            r_out_valid <= n_out_valid;
        end
        r_v        <= n_v;
        r_last     <= n_last;
        r_prime    <= n_prime;
        r_div      <= n_div;
        r_dsq      <= n_dsq;
        r_out_data <= n_out_data;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.largest_prime = r_out_data;

    // The squared bound tracks the divisor exactly while trials run.
    `LPIS_ASSERT_NOW(a_dsq_tracks_div, i_clk, i_rst_n, (r_state == ST_CHECK), (r_dsq == ({16'd0, r_div} * {16'd0, r_div})))
    // Trial divisors stay odd.
    `LPIS_ASSERT_NOW(a_div_odd, i_clk, i_rst_n, (r_state == ST_CHECK) || (r_state == ST_DIV), r_div[0])
    // The remainder unit reports only while the sequencer waits for it.
    `LPIS_ASSERT_NOW(a_rem_done_in_div, i_clk, i_rst_n, s_rem_status.done, (r_state == ST_DIV))
    // Emitting a result clears the running maximum for the next set.
    `LPIS_ASSERT_NEXT(a_best_cleared, i_clk, i_rst_n, w_emit, (r_best == '0) && r_out_valid)

endmodule
